// ===== rtl/core/bbp_pkg.sv =====
// Shared widths, codes and reset values for the broadcast buffer pool.
`default_nettype none

package bbp_pkg;

   // Beat field widths.
   localparam int ACTION_W   = 2;
   localparam int PORT_W     = 8;
   localparam int BUF_W      = 4;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 4;
   localparam int OFFSET_W   = 20;
   localparam int WRITER_W   = 8;

   // Configuration register widths and port shape.
   localparam int RCOUNT_W   = 4;
   localparam int ISIZE_W    = 17;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 2;

   // Default pool geometry.
   localparam int DEF_NUM_SLOTS   = 16;
   localparam int DEF_MAX_READERS = 8;

   // Register values after reset.
   localparam logic [RCOUNT_W-1:0] RESET_READER_COUNT = RCOUNT_W'(1);
   localparam logic [ISIZE_W-1:0]  RESET_ITEM_SIZE    = ISIZE_W'(64);

   // Operation codes.
   localparam logic [ACTION_W-1:0] ACT_WR_ACQUIRE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WR_FINISH  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RD_ACQUIRE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_RD_FINISH  = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSTANDING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_READER  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD    = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_READER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_SIZE    = 2'd1;

endpackage

`default_nettype wire

// ===== rtl/core/bbp_req_if.sv =====
// Request channel: one pool operation per beat.
`default_nettype none

interface bbp_req_if import bbp_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PORT_W-1:0]   port_id;
   logic [BUF_W-1:0]    buffer_id;

   modport source (output valid, action, port_id, buffer_id, input ready);
   modport sink   (input valid, action, port_id, buffer_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bbp_rsp_if.sv =====
// Response channel: one operation result per beat.
`default_nettype none

interface bbp_rsp_if import bbp_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_id;
   logic [OFFSET_W-1:0] slot_offset;
   logic [WRITER_W-1:0] writer_id;

   modport source (output valid, status, slot_id, slot_offset, writer_id, input ready);
   modport sink   (input valid, status, slot_id, slot_offset, writer_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/broadcast_buffer_pool_core.sv =====
// Reference-counted multicast buffer pool: free queue, per-reader queues, slot counts.
// A request beat is registered in the input register at acceptance, and its response is
// registered in the result register once that register can take a beat.
// Throughput: one request per cycle unless responses stall, set by the single update stage.
// Reset: synchronous; afterwards all slots are free in id order, reader queues
// are empty, reader_count is 1 and item_size is 64. There is no clearing pass.
`default_nettype none

module broadcast_buffer_pool_core import bbp_pkg::*; #(
   parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
   parameter int MAX_READERS = DEF_MAX_READERS
) (
   input  wire                    clock,
   input  wire                    reset,
   bbp_req_if.sink                req_bus,
   bbp_rsp_if.source              rsp_bus,
   input  wire                    csr_wr_en,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SW  = $clog2(NUM_SLOTS);
   localparam int CW  = $clog2(NUM_SLOTS + 1);
   localparam int RW  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
   localparam int RCW = $clog2(MAX_READERS + 1);
   localparam int PW  = SW + ISIZE_W;

   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(NUM_SLOTS);

   // Wrap a head-plus-count sum back into the slot range.
   function automatic logic [SW-1:0] slot_wrap(input logic [SW:0] v);
      logic [SW:0] limit;
      limit = (SW + 1)'(NUM_SLOTS);
      if (v >= limit) begin
         slot_wrap = SW'(v - limit);
      end else begin
         slot_wrap = SW'(v);
      end
   endfunction

   // Configuration registers.
   logic [RCOUNT_W-1:0] reader_count_ff;
   logic [ISIZE_W-1:0]  item_size_ff;

   // Input register.
   logic                s1_valid_ff;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [PORT_W-1:0]   s1_port_ff;
   logic [BUF_W-1:0]    s1_buf_ff;

   // Result register.
   logic                out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [SLOT_W-1:0]   out_slot_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   logic [WRITER_W-1:0] out_writer_ff;
   logic [STATUS_W-1:0] out_status_in;
   logic [SLOT_W-1:0]   out_slot_in;
   logic [OFFSET_W-1:0] out_offset_in;
   logic [WRITER_W-1:0] out_writer_in;

   // Free-id queue; an entry never written holds its own index.
   logic [SW-1:0]        free_mem_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] free_wr_ff;
   logic [SW-1:0]        free_head_ff;
   logic [CW-1:0]        free_cnt_ff;
   logic [SW-1:0]        free_tail;
   logic [SW-1:0]        free_head_val;

   // Per-reader queues.
   logic [SW-1:0] rd_mem_ff  [MAX_READERS][NUM_SLOTS];
   logic [SW-1:0] rd_head_ff [MAX_READERS];
   logic [CW-1:0] rd_cnt_ff  [MAX_READERS];
   logic [SW-1:0] rd_tail    [MAX_READERS];

   // Per-slot reference counts and writer ids.
   logic [RCW-1:0]      pend_ff   [NUM_SLOTS];
   logic [WRITER_W-1:0] writer_ff [NUM_SLOTS];

   // Operation decode.
   logic            out_open;
   logic            fire;
   logic [RCW-1:0]  active_rc;
   logic            bid_ok;
   logic [SW-1:0]   bid_idx;
   logic            port_ok;
   logic [RW-1:0]   rd_idx;
   logic [SW-1:0]   sid;
   logic            granted;
   logic [PW-1:0]   product;
   logic            free_pop;
   logic            free_push;
   logic            rd_pop;
   logic            wr_arm;
   logic            pend_dec;

   // Handshake: the input register moves on whenever the result register can take a beat.
   assign out_open      = !out_valid_ff || rsp_bus.ready;
   assign fire          = s1_valid_ff && out_open;
   assign req_bus.ready = !s1_valid_ff || fire;

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_status_ff;
   assign rsp_bus.slot_id     = out_slot_ff;
   assign rsp_bus.slot_offset = out_offset_ff;
   assign rsp_bus.writer_id   = out_writer_ff;

   // Effective reader count: zero acts as one, large values clamp.
   always_comb begin
      if (reader_count_ff == '0) begin
         active_rc = RCW'(1);
      end else if (32'(reader_count_ff) > MAX_READERS) begin
         active_rc = RCW'(MAX_READERS);
      end else begin
         active_rc = RCW'(reader_count_ff);
      end
   end

   // Queue tails and the free queue's head entry.
   always_comb begin
      free_tail     = slot_wrap({1'b0, free_head_ff} + (SW + 1)'(free_cnt_ff));
      free_head_val = free_wr_ff[free_head_ff] ? free_mem_ff[free_head_ff] : free_head_ff;
      for (int r = 0; r < MAX_READERS; r++) begin
         rd_tail[r] = slot_wrap({1'b0, rd_head_ff[r]} + (SW + 1)'(rd_cnt_ff[r]));
      end
   end

   assign bid_ok  = 32'(s1_buf_ff) < NUM_SLOTS;
   assign bid_idx = SW'(s1_buf_ff);
   assign port_ok = 32'(s1_port_ff) < 32'(active_rc);
   assign rd_idx  = RW'(s1_port_ff);

   // Operation decode and result selection.
   always_comb begin
      out_status_in = ST_OK;
      out_writer_in = '0;
      sid           = '0;
      granted       = 1'b0;
      free_pop      = 1'b0;
      free_push     = 1'b0;
      rd_pop        = 1'b0;
      wr_arm        = 1'b0;
      pend_dec      = 1'b0;
      unique case (s1_action_ff)
         ACT_WR_ACQUIRE: begin
            if (free_cnt_ff != '0) begin
               sid      = free_head_val;
               granted  = 1'b1;
               free_pop = 1'b1;
            end else begin
               out_status_in = ST_EMPTY;
            end
         end
         ACT_WR_FINISH: begin
            if (!bid_ok) begin
               out_status_in = ST_NOT_HELD;
            end else if (pend_ff[bid_idx] != '0) begin
               out_status_in = ST_OUTSTANDING;
            end else begin
               wr_arm = 1'b1;
            end
         end
         ACT_RD_ACQUIRE: begin
            if (!port_ok) begin
               out_status_in = ST_BAD_READER;
            end else if (rd_cnt_ff[rd_idx] != '0) begin
               sid           = rd_mem_ff[rd_idx][rd_head_ff[rd_idx]];
               out_writer_in = writer_ff[sid];
               granted       = 1'b1;
               rd_pop        = 1'b1;
            end else begin
               out_status_in = ST_EMPTY;
            end
         end
         ACT_RD_FINISH: begin
            if (!bid_ok) begin
               out_status_in = ST_NOT_HELD;
            end else if (pend_ff[bid_idx] == '0) begin
               out_status_in = ST_NOT_HELD;
            end else begin
               pend_dec  = 1'b1;
               free_push = pend_ff[bid_idx] == RCW'(1);
            end
         end
      endcase
   end

   // Byte offset of the granted slot, truncated to the field width.
   assign product       = PW'(sid) * PW'(item_size_ff);
   assign out_slot_in   = granted ? SLOT_W'(sid) : '0;
   assign out_offset_in = granted ? OFFSET_W'(product) : '0;

   // Control state, counts and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         reader_count_ff <= RESET_READER_COUNT;
         item_size_ff    <= RESET_ITEM_SIZE;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         free_wr_ff      <= '0;
         free_head_ff    <= '0;
         free_cnt_ff     <= FULL_CNT;
         for (int r = 0; r < MAX_READERS; r++) begin
            rd_head_ff[r] <= '0;
            rd_cnt_ff[r]  <= '0;
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            pend_ff[s] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_READER_COUNT: reader_count_ff <= RCOUNT_W'(csr_wdata);
               CSR_ITEM_SIZE:    item_size_ff    <= ISIZE_W'(csr_wdata);
               default: ;
            endcase
         end

         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (out_open) begin
            out_valid_ff <= s1_valid_ff;
         end

         // Free queue pointers; a pop and a push never share a cycle.
         if (fire && free_pop) begin
            free_head_ff <= (free_head_ff == LAST_SLOT) ? '0 : free_head_ff + 1'b1;
            free_cnt_ff  <= free_cnt_ff - 1'b1;
         end else if (fire && free_push && free_cnt_ff != FULL_CNT) begin
            free_wr_ff[free_tail] <= 1'b1;
            free_cnt_ff           <= free_cnt_ff + 1'b1;
         end

         // Reader queue pointers: broadcast push or a single pop.
         for (int r = 0; r < MAX_READERS; r++) begin
            if (fire && wr_arm && 32'(r) < 32'(active_rc) && rd_cnt_ff[r] != FULL_CNT) begin
               rd_cnt_ff[r] <= rd_cnt_ff[r] + 1'b1;
            end else if (fire && rd_pop && 32'(rd_idx) == r) begin
               rd_head_ff[r] <= (rd_head_ff[r] == LAST_SLOT) ? '0 : rd_head_ff[r] + 1'b1;
               rd_cnt_ff[r]  <= rd_cnt_ff[r] - 1'b1;
            end
         end

         // Reference counts.
         if (fire && wr_arm) begin
            pend_ff[bid_idx] <= active_rc;
         end else if (fire && pend_dec) begin
            pend_ff[bid_idx] <= pend_ff[bid_idx] - 1'b1;
         end
      end
   end

   // Payload registers and queue storage.
   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         s1_action_ff <= req_bus.action;
         s1_port_ff   <= req_bus.port_id;
         s1_buf_ff    <= req_bus.buffer_id;
      end
      if (out_open) begin
         out_status_ff <= out_status_in;
         out_slot_ff   <= out_slot_in;
         out_offset_ff <= out_offset_in;
         out_writer_ff <= out_writer_in;
      end
      if (fire && free_push && free_cnt_ff != FULL_CNT) begin
         free_mem_ff[free_tail] <= bid_idx;
      end
      for (int r = 0; r < MAX_READERS; r++) begin
         if (fire && wr_arm && 32'(r) < 32'(active_rc) && rd_cnt_ff[r] != FULL_CNT) begin
            rd_mem_ff[r][rd_tail[r]] <= bid_idx;
         end
      end
      if (fire && wr_arm) begin
         writer_ff[bid_idx] <= s1_port_ff;
      end
   end

`ifndef SYNTH
   // The free queue never holds more ids than there are slots.
   a_free_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= FULL_CNT)
      else $error("free queue count above slot count");

   // A granted write acquire removes exactly one id from the free queue.
   a_free_pop: assert property (@(posedge clock) disable iff (reset)
      fire && s1_action_ff == ACT_WR_ACQUIRE && free_cnt_ff != '0
      |=> free_cnt_ff == $past(free_cnt_ff) - 1'b1)
      else $error("write acquire did not pop the free queue");

   // A failed operation carries no slot, offset or writer.
   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != ST_OK
      |-> out_slot_ff == '0 && out_offset_ff == '0 && out_writer_ff == '0)
      else $error("error response with nonzero payload");

   // Requests are refused only when both stages are full and the response is stalled.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> s1_valid_ff && out_valid_ff && !rsp_bus.ready)
      else $error("request refused without downstream backpressure");
`endif

endmodule

`default_nettype wire

// ===== sim/broadcast_buffer_pool_core_test.sv =====
// Self-checking testbench for the broadcast buffer pool core.
`timescale 1ns / 1ps

module broadcast_buffer_pool_core_test import bbp_pkg::*;;

   localparam int NSLOTS       = DEF_NUM_SLOTS;
   localparam int NREADERS     = DEF_MAX_READERS;
   localparam int FREE_Q       = NREADERS;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BEATS  = 220;
   localparam int MAX_PRINTS   = 30;

   // One response beat as the pool should produce it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [OFFSET_W-1:0] offset;
      logic [WRITER_W-1:0] writer;
   } pool_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bbp_req_if req_bus ();
   bbp_rsp_if rsp_bus ();

   broadcast_buffer_pool_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the pool: queues 0..7 belong to readers, the last one is the free queue.
   logic [BUF_W-1:0]    q_mem [NREADERS+1][NSLOTS];
   int                  q_head [NREADERS+1];
   int                  q_cnt [NREADERS+1];
   int                  slot_refs [NSLOTS];
   logic [WRITER_W-1:0] slot_owner [NSLOTS];
   logic [RCOUNT_W-1:0] cfg_readers;
   logic [ISIZE_W-1:0]  cfg_size;

   // Responses owed by the pool, oldest first.
   pool_rsp_type pending_rsp [$];

   // Slots held by writers (acquired, not finished) and by readers (acquired, not released).
   logic [BUF_W-1:0] writer_held [$];
   logic [BUF_W-1:0] reader_held [$];

   bit send_idle;
   bit recv_idle;
   bit hold_request;
   int err_count;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Overall time limit in case the pool stops answering.
   initial begin
      #3_000_000;
      $display("TIMEOUT: %0d responses still outstanding", pending_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Mismatch reporting: every one is counted, only the first few are printed.
   task automatic report_mismatch(input string what, input int got_val, input int want_val);
      if (err_count < MAX_PRINTS)
         $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $realtime, what, got_val,
                  want_val);
      err_count++;
   endtask

   // Random idle length: mostly none or short, now and then long.
   function automatic int idle_len(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Reader count as the pool applies it: zero acts as one, large values are clamped.
   function automatic int live_readers();
      if (cfg_readers == 0) return 1;
      if (cfg_readers > NREADERS) return NREADERS;
      return int'(cfg_readers);
   endfunction

   // Queue push; a push into a full queue is dropped.
   function automatic void q_push(input int q, input logic [BUF_W-1:0] v);
      if (q_cnt[q] < NSLOTS) begin
         q_mem[q][(q_head[q] + q_cnt[q]) % NSLOTS] = v;
         q_cnt[q]++;
      end
   endfunction

   function automatic bit q_pop(input int q, output logic [BUF_W-1:0] v);
      v = '0;
      if (q_cnt[q] == 0) return 1'b0;
      v = q_mem[q][q_head[q]];
      q_head[q] = (q_head[q] + 1) % NSLOTS;
      q_cnt[q]--;
      return 1'b1;
   endfunction

   // Applies one operation to the shadow pool and returns the response it must cause.
   function automatic pool_rsp_type pool_apply(input logic [ACTION_W-1:0] act,
                                               input logic [PORT_W-1:0] port,
                                               input logic [BUF_W-1:0] bid);
      pool_rsp_type r;
      logic [BUF_W-1:0] sid;
      logic [39:0] prod;
      bit granted;
      int rc;
      int i;
      r = '0;
      r.status = ST_OK;
      sid = '0;
      granted = 1'b0;
      rc = live_readers();
      // The slot field is four bits wide, so an id past the pool cannot occur here.
      case (act)
         ACT_WR_ACQUIRE: begin
            if (q_pop(FREE_Q, sid)) granted = 1'b1;
            else r.status = ST_EMPTY;
         end
         ACT_WR_FINISH: begin
            if (slot_refs[bid] != 0) begin
               r.status = ST_OUTSTANDING;
            end else begin
               slot_refs[bid] = rc;
               slot_owner[bid] = port;
               for (i = 0; i < rc; i++) q_push(i, bid);
            end
         end
         ACT_RD_ACQUIRE: begin
            if (int'(port) >= rc) begin
               r.status = ST_BAD_READER;
            end else if (q_pop(int'(port), sid)) begin
               granted = 1'b1;
               r.writer = slot_owner[sid];
            end else begin
               r.status = ST_EMPTY;
            end
         end
         ACT_RD_FINISH: begin
            if (slot_refs[bid] == 0) begin
               r.status = ST_NOT_HELD;
            end else begin
               slot_refs[bid]--;
               if (slot_refs[bid] == 0) q_push(FREE_Q, bid);
            end
         end
      endcase
      // Granted slots report their byte offset, truncated to the field width.
      if (granted) begin
         prod = 40'(sid) * 40'(cfg_size);
         r.slot = sid;
         r.offset = prod[OFFSET_W-1:0];
      end
      return r;
   endfunction

   // Sends one request beat and records the response it must cause.
   task automatic send_op(input logic [ACTION_W-1:0] act, input logic [PORT_W-1:0] port,
                          input logic [BUF_W-1:0] bid, output pool_rsp_type want);
      int gap;
      gap = idle_len(send_idle);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.port_id   <= port;
      req_bus.buffer_id <= bid;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = pool_apply(act, port, bid);
      pending_rsp.push_back(want);
   endtask

   // Stops sending and waits until every owed response has come back.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both registers while the pool is idle.
   task automatic set_pool_config(input logic [RCOUNT_W-1:0] readers,
                                  input logic [ISIZE_W-1:0] size);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_READER_COUNT;
      csr_wdata <= CSR_DATA_W'(readers);
      @(posedge clock);
      csr_index <= CSR_ITEM_SIZE;
      csr_wdata <= CSR_DATA_W'(size);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_readers = readers;
      cfg_size = size;
   endtask

   // One random operation, mostly following the acquire/finish life cycle of a slot.
   task automatic random_op();
      pool_rsp_type got;
      logic [BUF_W-1:0] bid;
      logic [PORT_W-1:0] port;
      int roll;
      int k;
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
         send_op(ACT_WR_ACQUIRE, PORT_W'($urandom_range(0, 255)),
                 BUF_W'($urandom_range(0, 15)), got);
         if (got.status == ST_OK) writer_held.push_back(got.slot);
      end else if (roll < 42) begin
         bid = BUF_W'($urandom_range(0, 15));
         if (writer_held.size() > 0) begin
            k = $urandom_range(0, writer_held.size() - 1);
            bid = writer_held[k];
            writer_held.delete(k);
         end
         send_op(ACT_WR_FINISH, PORT_W'($urandom_range(0, 255)), bid, got);
      end else if (roll < 70) begin
         // A few reads use any reader index at all.
         if (roll < 66) port = PORT_W'($urandom_range(0, live_readers() - 1));
         else port = PORT_W'($urandom_range(0, 255));
         send_op(ACT_RD_ACQUIRE, port, BUF_W'($urandom_range(0, 15)), got);
         if (got.status == ST_OK) reader_held.push_back(got.slot);
      end else if (roll < 94) begin
         bid = BUF_W'($urandom_range(0, 15));
         if (reader_held.size() > 0) begin
            k = $urandom_range(0, reader_held.size() - 1);
            bid = reader_held[k];
            reader_held.delete(k);
         end
         send_op(ACT_RD_FINISH, PORT_W'($urandom_range(0, 255)), bid, got);
      end else begin
         send_op(ACTION_W'($urandom_range(0, 3)), PORT_W'($urandom_range(0, 255)),
                 BUF_W'($urandom_range(0, 15)), got);
      end
   endtask

   // Every operation and its error cases with the reset configuration.
   task automatic test_basic_ops();
      pool_rsp_type got;
      logic [BUF_W-1:0] first_slot;
      logic [BUF_W-1:0] second_slot;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_op(ACT_WR_ACQUIRE, 8'hFF, 4'hF, got);
      first_slot = got.slot;
      send_op(ACT_WR_ACQUIRE, 8'h00, 4'h0, got);
      second_slot = got.slot;
      send_op(ACT_WR_FINISH, 8'hAA, second_slot, got);
      // A second finish while the reader still holds the slot.
      send_op(ACT_WR_FINISH, 8'h55, second_slot, got);
      send_op(ACT_RD_ACQUIRE, 8'd0, 4'h0, got);
      send_op(ACT_RD_ACQUIRE, 8'd0, 4'h0, got);
      send_op(ACT_RD_ACQUIRE, 8'd1, 4'h0, got);
      send_op(ACT_RD_ACQUIRE, 8'hFF, 4'hF, got);
      send_op(ACT_RD_FINISH, 8'h00, second_slot, got);
      // Releases on a slot whose count is already zero.
      send_op(ACT_RD_FINISH, 8'hFF, second_slot, got);
      send_op(ACT_RD_FINISH, 8'h00, 4'd5, got);
      // Finishing a slot that was never handed to a writer is accepted.
      send_op(ACT_WR_FINISH, 8'h55, 4'd9, got);
      send_op(ACT_RD_ACQUIRE, 8'd0, 4'h0, got);
      send_op(ACT_RD_FINISH, 8'h00, 4'd9, got);
      // The free queue is full again, so the next release is dropped.
      send_op(ACT_WR_FINISH, 8'h00, first_slot, got);
      send_op(ACT_RD_ACQUIRE, 8'd0, 4'h0, got);
      send_op(ACT_RD_FINISH, 8'h00, first_slot, got);
   endtask

   // Reader counts outside the legal range, a slot size of one and the largest slot size.
   task automatic test_config_extremes();
      pool_rsp_type got;
      logic [BUF_W-1:0] s;
      set_pool_config(RCOUNT_W'(0), ISIZE_W'(1));
      send_op(ACT_WR_ACQUIRE, 8'h01, 4'h0, got);
      s = got.slot;
      send_op(ACT_WR_FINISH, 8'hFF, s, got);
      send_op(ACT_RD_ACQUIRE, 8'd0, 4'h0, got);
      send_op(ACT_RD_ACQUIRE, 8'd1, 4'h0, got);
      send_op(ACT_RD_FINISH, 8'h00, s, got);
      set_pool_config(RCOUNT_W'(15), ISIZE_W'(131071));
      send_op(ACT_WR_ACQUIRE, 8'h80, 4'h0, got);
      s = got.slot;
      send_op(ACT_WR_FINISH, 8'h0F, s, got);
      send_op(ACT_RD_ACQUIRE, 8'd7, 4'h0, got);
      send_op(ACT_RD_ACQUIRE, 8'd8, 4'h0, got);
      send_op(ACT_RD_FINISH, 8'h00, s, got);
   endtask

   // Drains the free queue past empty; high slots with the largest size overflow the offset.
   task automatic test_pool_exhaustion();
      pool_rsp_type got;
      int n;
      for (n = 0; n <= NSLOTS; n++) begin
         send_op(ACT_WR_ACQUIRE, PORT_W'($urandom_range(0, 255)),
                 BUF_W'($urandom_range(0, 15)), got);
         if (got.status == ST_OK) writer_held.push_back(got.slot);
      end
   endtask

   // Fills reader 0's queue and the free queue until pushes are dropped.
   task automatic test_queue_limits();
      pool_rsp_type got;
      logic [BUF_W-1:0] b;
      int n;
      set_pool_config(RCOUNT_W'(1), ISIZE_W'(65536));
      b = '0;
      if (writer_held.size() > 0) b = writer_held.pop_front();
      for (n = 0; n <= NSLOTS; n++) begin
         send_op(ACT_WR_FINISH, PORT_W'($urandom_range(0, 255)), b, got);
         send_op(ACT_RD_FINISH, PORT_W'($urandom_range(0, 255)), b, got);
      end
      send_op(ACT_RD_ACQUIRE, 8'd0, 4'h0, got);
      send_op(ACT_RD_ACQUIRE, 8'd0, 4'h0, got);
   endtask

   // Random traffic over a series of configurations, idling switched on and off.
   task automatic test_random_traffic();
      logic [RCOUNT_W-1:0] readers;
      logic [ISIZE_W-1:0] size;
      int phase;
      int n;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin readers = RCOUNT_W'(1);  size = ISIZE_W'(64);     end
            1: begin readers = RCOUNT_W'(8);  size = ISIZE_W'(65536);  end
            2: begin readers = RCOUNT_W'(15); size = ISIZE_W'(131071); end
            3: begin readers = RCOUNT_W'(0);  size = ISIZE_W'(1);      end
            4: begin readers = RCOUNT_W'(2);  size = ISIZE_W'(0);      end
            default: begin
               readers = RCOUNT_W'($urandom_range(0, 15));
               size = ISIZE_W'($urandom_range(0, 131071));
            end
         endcase
         set_pool_config(readers, size);
         for (n = 0; n < PHASE_BEATS; n++) begin
            if (n % 40 == 0) begin
               send_idle = ($urandom_range(0, 3) != 0);
               recv_idle = ($urandom_range(0, 3) != 0);
            end
            random_op();
         end
      end
   endtask

   // Long response stall while requests keep coming, then a full drain before more traffic.
   task automatic test_full_backpressure();
      int n;
      wait_idle();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      hold_request = 1'b1;
      for (n = 0; n < 48; n++) random_op();
      wait_idle();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      for (n = 0; n < 40; n++) random_op();
   endtask

   // Response ready: random stalls, or a long hold when the test asks for one.
   initial begin : rsp_ready_gen
      int stall;
      forever begin
         stall = idle_len(recv_idle);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Response check: each accepted beat against the oldest owed response.
   always @(posedge clock) begin : rsp_check
      pool_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response beat, status", rsp_bus.status, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.slot_id !== want.slot)
               report_mismatch("slot_id", rsp_bus.slot_id, want.slot);
            if (rsp_bus.slot_offset !== want.offset)
               report_mismatch("slot_offset", rsp_bus.slot_offset, want.offset);
            if (rsp_bus.writer_id !== want.writer)
               report_mismatch("writer_id", rsp_bus.writer_id, want.writer);
         end
      end
   end

   // Main sequence.
   initial begin : main_seq
      int i;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.action    <= ACT_WR_ACQUIRE;
      req_bus.port_id   <= '0;
      req_bus.buffer_id <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_READER_COUNT;
      csr_wdata         <= '0;

      // Shadow pool after reset: all slots free in id order, reader queues empty.
      cfg_readers = RESET_READER_COUNT;
      cfg_size = RESET_ITEM_SIZE;
      for (i = 0; i <= NREADERS; i++) begin
         q_head[i] = 0;
         q_cnt[i] = 0;
      end
      for (i = 0; i < NSLOTS; i++) begin
         q_mem[FREE_Q][i] = BUF_W'(i);
         slot_refs[i] = 0;
         slot_owner[i] = '0;
      end
      q_cnt[FREE_Q] = NSLOTS;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_config_extremes();
      test_pool_exhaustion();
      test_queue_limits();
      test_random_traffic();
      test_full_backpressure();
      wait_idle();

      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
